// ===== src/klst_pkg.sv =====
// klst_pkg: record type, action and status codes for the keyed LIFO stack.
// No dependencies; used by klst_store and keyed_lifo_stack.
package klst_pkg;

    typedef struct packed {
        logic signed [7:0] temperature;
        logic [6:0]        humidity;
        logic [4:0]        hour;
    } t_rec;

    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_POP    = 3'd1;
    localparam logic [2:0] ACT_LOOKUP = 3'd2;
    localparam logic [2:0] ACT_DUMP   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_DUP      = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_EMPTY    = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

endpackage

// ===== src/keyed_lifo_stack.sv =====
// keyed_lifo_stack: LIFO of sensor records keyed by hour, with push, pop,
// lookup, dump and clear. Depends on klst_pkg and klst_store.
//
//  channel      dir  handshake                      payload
//  s_axis       in   i_s_axis_tvalid/o_s_axis_tready tuser action, tdata record
//  m_axis       out  o_m_axis_tvalid/i_m_axis_tready tuser status, tdata record
//
// One key comparator walks the memory, one entry per cycle, behind the
// registered read port. Push and lookup scan from the bottom and stop early
// on a hit; pop reads the top record; dump reads and emits records top down.
// One item is in work at a time; s_axis is ready only while idle.
// Reset (synchronous, active low) empties the stack; memory contents are
// not cleared. A stalled m_axis holds the result and the sequencer waits.
module keyed_lifo_stack #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // temperature[7:0], humidity[14:8], hour[19:15]
    input  logic [2:0]  i_s_axis_tuser,  // action[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // out_temperature[7:0], out_humidity[14:8],
                                         // out_hour[19:15]
    output logic [3:0]  o_m_axis_tuser,  // status[2:0], has_record[3]
    output logic        o_m_axis_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]     r_state, n_state;
    logic [2:0]     r_action, n_action;
    klst_pkg::t_rec r_new, n_new;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_cmp_vld, n_cmp_vld;
    logic [2:0]     r_res_status, n_res_status;
    logic           r_res_has, n_res_has;
    klst_pkg::t_rec r_res_rec, n_res_rec;
    logic           r_res_last, n_res_last;
    logic           r_out_valid, n_out_valid;
    logic [2:0]     r_out_status, n_out_status;
    logic           r_out_has, n_out_has;
    klst_pkg::t_rec r_out_rec, n_out_rec;
    logic           r_out_last, n_out_last;

    logic           w_acc;
    logic           w_out_free;
    klst_pkg::t_rec w_in_rec;
    logic           w_we;
    logic           w_re;
    logic [AW-1:0]  w_raddr;
    klst_pkg::t_rec w_rdata;
    logic [CW-1:0]  w_cnt_m1;
    logic [CW-1:0]  w_idx_m1;
    logic           w_scan_rd;
    logic           w_match;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    assign w_in_rec.temperature = i_s_axis_tdata[7:0];
    assign w_in_rec.humidity    = i_s_axis_tdata[14:8];
    assign w_in_rec.hour        = i_s_axis_tdata[19:15];

    assign w_cnt_m1  = r_count - 1'b1;
    assign w_idx_m1  = r_idx - 1'b1;
    assign w_scan_rd = (r_idx < r_count);
    // shared key comparator, fed by the registered read port
    assign w_match   = r_cmp_vld && (w_rdata.hour == r_new.hour);

    klst_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_new),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_new        = r_new;
        n_count      = r_count;
        n_idx        = r_idx;
        n_cmp_vld    = 1'b0;
        n_res_status = r_res_status;
        n_res_has    = r_res_has;
        n_res_rec    = r_res_rec;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_has    = r_out_has;
        n_out_rec    = r_out_rec;
        n_out_last   = r_out_last;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_raddr      = r_idx[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_action     = i_s_axis_tuser;
                    n_new        = w_in_rec;
                    n_res_status = klst_pkg::STAT_OK;
                    n_res_has    = 1'b0;
                    n_res_rec    = '0;
                    n_res_last   = 1'b1;
                    case (i_s_axis_tuser)
                        klst_pkg::ACT_PUSH, klst_pkg::ACT_LOOKUP: begin
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        klst_pkg::ACT_POP, klst_pkg::ACT_DUMP: begin
                            if (r_count == '0) begin
                                n_res_status = klst_pkg::STAT_EMPTY;
                                n_state      = ST_EMIT;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_cnt_m1[AW-1:0];
                                n_idx   = w_cnt_m1;
                                if (i_s_axis_tuser == klst_pkg::ACT_POP) begin
                                    n_count = w_cnt_m1;
                                end
                                n_state = ST_READ;
                            end
                        end
                        klst_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_state = ST_IDLE;  // unused codes give no result
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                w_re      = w_scan_rd;
                n_cmp_vld = w_scan_rd;
                if (w_scan_rd) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_match) begin
                    n_cmp_vld = 1'b0;
                    if (r_action == klst_pkg::ACT_PUSH) begin
                        n_res_status = klst_pkg::STAT_DUP;
                    end else begin
                        n_res_status = klst_pkg::STAT_OK;
                        n_res_has    = 1'b1;
                        n_res_rec    = w_rdata;
                    end
                    n_state = ST_EMIT;
                end else if (!w_scan_rd && !r_cmp_vld) begin
                    // every stored key compared, no hit
                    if (r_action == klst_pkg::ACT_PUSH) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_status = klst_pkg::STAT_FULL;
                        end else begin
                            w_we         = 1'b1;
                            n_count      = r_count + 1'b1;
                            n_res_status = klst_pkg::STAT_OK;
                        end
                    end else begin
                        n_res_status = klst_pkg::STAT_NOTFOUND;
                    end
                    n_state = ST_EMIT;
                end
            end

            ST_READ: begin
                n_res_status = klst_pkg::STAT_OK;
                n_res_has    = 1'b1;
                n_res_rec    = w_rdata;
                n_res_last   = (r_action == klst_pkg::ACT_POP) || (r_idx == '0);
                n_state      = ST_EMIT;
            end

            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_has    = r_res_has;
                    n_out_rec    = r_res_rec;
                    n_out_last   = r_res_last;
                    if (r_action == klst_pkg::ACT_DUMP && !r_res_last) begin
                        w_re    = 1'b1;
                        w_raddr = w_idx_m1[AW-1:0];
                        n_idx   = w_idx_m1;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_new        <= n_new;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_has    <= n_res_has;
        r_res_rec    <= n_res_rec;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_has    <= n_out_has;
        r_out_rec    <= n_out_rec;
        r_out_last   <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_rec.hour, r_out_rec.humidity,
                              r_out_rec.temperature};
    assign o_m_axis_tuser  = {r_out_has, r_out_status};
    assign o_m_axis_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_count < CW'(DEPTH)))
        else $error("write into a full stack");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_count))
        else $error("scan index ran past fill count");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_axis_tuser == klst_pkg::ACT_POP && r_count != '0)
        |=> (r_count == $past(w_cnt_m1)))
        else $error("pop did not drop the fill count");

    a_read_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> $stable(r_count))
        else $error("fill count moved while reading a record");

endmodule

// ===== src/klst_store.sv =====
// klst_store: record memory, one write port and one registered read port.
// Depends on klst_pkg for the record type.
module klst_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  klst_pkg::t_rec      i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output klst_pkg::t_rec      o_rdata
);

    klst_pkg::t_rec r_mem [DEPTH];
    klst_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for keyed_lifo_stack; a directed table and random
// push/pop/lookup/dump/clear traffic are scored against a shadow stack of records.
// Depends on klst_pkg and keyed_lifo_stack.
module tb_top;

    localparam int DEPTH       = 32;
    localparam int ITEM_TARGET = 330;
    localparam int IDLE_PCT    = 28;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 40;

    // action codes the block ignores
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0]     status;
        logic           has_rec;
        klst_pkg::t_rec rec;
        logic           last;
    } t_answer;

    // directed table row; want is used only when typed is set
    typedef struct packed {
        logic [2:0] act;
        logic [7:0] temp;
        logic [6:0] hum;
        logic [4:0] hour;
        logic       typed;
        logic [2:0] want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // temperature[7:0], humidity[14:8], hour[19:15]
    logic [2:0]  i_s_axis_tuser;   // action[2:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // out_temperature[7:0], out_humidity[14:8], out_hour[19:15]
    logic [3:0]  o_m_axis_tuser;   // status[2:0], has_record[3]
    logic        o_m_axis_tlast;

    klst_pkg::t_rec shadow_rec [DEPTH];
    int             shadow_fill;
    t_answer        answers_due [$];
    int             fails;
    int             results_seen;
    int             items_sent;
    int             quiet_cycles;
    bit             steady;

    t_row dir_rows [23] = '{
        {klst_pkg::ACT_POP,    8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_EMPTY},
        {klst_pkg::ACT_DUMP,   8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_EMPTY},
        {klst_pkg::ACT_LOOKUP, 8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_NOTFOUND},
        {klst_pkg::ACT_PUSH,   8'h80, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_OK},
        {klst_pkg::ACT_PUSH,   8'h7F, 7'd127, 5'd31, 1'b1, klst_pkg::STAT_OK},
        {klst_pkg::ACT_PUSH,   8'h55, 7'd42,  5'd0,  1'b1, klst_pkg::STAT_DUP},
        {klst_pkg::ACT_LOOKUP, 8'h00, 7'd0,   5'd31, 1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_LOOKUP, 8'hFF, 7'd127, 5'd0,  1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_LOOKUP, 8'h00, 7'd0,   5'd12, 1'b1, klst_pkg::STAT_NOTFOUND},
        {klst_pkg::ACT_DUMP,   8'h00, 7'd0,   5'd0,  1'b0, klst_pkg::STAT_OK},
        {ACT_RSVD5,            8'h12, 7'd5,   5'd3,  1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_POP,    8'h00, 7'd0,   5'd0,  1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_PUSH,   8'hFF, 7'd100, 5'd23, 1'b1, klst_pkg::STAT_OK},
        {klst_pkg::ACT_PUSH,   8'h01, 7'd101, 5'd16, 1'b1, klst_pkg::STAT_OK},
        {ACT_RSVD7,            8'hAA, 7'd77,  5'd9,  1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_DUMP,   8'h00, 7'd0,   5'd0,  1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_LOOKUP, 8'h00, 7'd0,   5'd23, 1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_POP,    8'h00, 7'd0,   5'd0,  1'b0, klst_pkg::STAT_OK},
        {klst_pkg::ACT_CLEAR,  8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_OK},
        {klst_pkg::ACT_POP,    8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_EMPTY},
        {klst_pkg::ACT_LOOKUP, 8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_NOTFOUND},
        {klst_pkg::ACT_DUMP,   8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_EMPTY},
        {klst_pkg::ACT_CLEAR,  8'h00, 7'd0,   5'd0,  1'b1, klst_pkg::STAT_OK}
    };

    keyed_lifo_stack #(.DEPTH(DEPTH)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_answer bare_answer(logic [2:0] status);
        t_answer a;
        a = '0;
        a.status = status;
        a.last   = 1'b1;
        return a;
    endfunction

    function automatic int find_hour(logic [4:0] hour);
        for (int i = 0; i < shadow_fill; i++)
            if (shadow_rec[i].hour == hour) return i;
        return -1;
    endfunction

    // apply one accepted item to the shadow stack and queue the answers it owes
    task automatic stack_apply(logic [2:0] act, klst_pkg::t_rec r);
        t_answer a;
        int      idx;
        case (act)
            klst_pkg::ACT_PUSH: begin
                if (find_hour(r.hour) >= 0) begin
                    answers_due.push_back(bare_answer(klst_pkg::STAT_DUP));
                end else if (shadow_fill >= DEPTH) begin
                    answers_due.push_back(bare_answer(klst_pkg::STAT_FULL));
                end else begin
                    shadow_rec[shadow_fill] = r;
                    shadow_fill++;
                    answers_due.push_back(bare_answer(klst_pkg::STAT_OK));
                end
            end
            klst_pkg::ACT_POP: begin
                if (shadow_fill == 0) begin
                    answers_due.push_back(bare_answer(klst_pkg::STAT_EMPTY));
                end else begin
                    shadow_fill--;
                    a = bare_answer(klst_pkg::STAT_OK);
                    a.has_rec = 1'b1;
                    a.rec = shadow_rec[shadow_fill];
                    answers_due.push_back(a);
                end
            end
            klst_pkg::ACT_LOOKUP: begin
                idx = find_hour(r.hour);
                if (idx < 0) begin
                    answers_due.push_back(bare_answer(klst_pkg::STAT_NOTFOUND));
                end else begin
                    a = bare_answer(klst_pkg::STAT_OK);
                    a.has_rec = 1'b1;
                    a.rec = shadow_rec[idx];
                    answers_due.push_back(a);
                end
            end
            klst_pkg::ACT_DUMP: begin
                if (shadow_fill == 0)
                    answers_due.push_back(bare_answer(klst_pkg::STAT_EMPTY));
                for (int i = shadow_fill - 1; i >= 0; i--) begin
                    a = bare_answer(klst_pkg::STAT_OK);
                    a.has_rec = 1'b1;
                    a.rec = shadow_rec[i];
                    a.last = (i == 0);
                    answers_due.push_back(a);
                end
            end
            klst_pkg::ACT_CLEAR: begin
                shadow_fill = 0;
                answers_due.push_back(bare_answer(klst_pkg::STAT_OK));
            end
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(logic [2:0] act, logic [7:0] temp, logic [6:0] hum,
                             logic [4:0] hour);
        klst_pkg::t_rec r;
        r.temperature = temp;
        r.humidity    = hum;
        r.hour        = hour;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {4'b0, hour, hum, temp};
        i_s_axis_tuser  = act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        stack_apply(act, r);
        if (act <= klst_pkg::ACT_CLEAR) items_sent++;
        steady = (items_sent >= 150 && items_sent < 200);
        @(negedge i_clk);
    endtask

    function automatic logic [6:0] rand_hum();
        if ($urandom_range(9) == 0) return 7'($urandom_range(101, 127));
        return 7'($urandom_range(100));
    endfunction

    // hour that is stored (or absent) when one exists, else any hour
    function automatic logic [4:0] pick_hour(bit stored);
        logic [4:0] pool [$];
        for (int h = 0; h < 32; h++)
            if ((find_hour(5'(h)) >= 0) == stored) pool.push_back(5'(h));
        if (pool.size() == 0) return 5'($urandom_range(31));
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic push_rand(bit fresh);
        send_item(klst_pkg::ACT_PUSH, 8'($urandom), rand_hum(), pick_hour(!fresh));
    endtask

    // clear, push every hour in shuffled order, then a refused push, a full dump and four lookups
    task automatic fill_to_top();
        logic [4:0] order [32];
        logic [4:0] t;
        int         j;
        for (int i = 0; i < 32; i++) order[i] = 5'(i);
        for (int i = 31; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        send_item(klst_pkg::ACT_CLEAR, 8'($urandom), rand_hum(), 5'($urandom));
        for (int i = 0; i < 32; i++)
            send_item(klst_pkg::ACT_PUSH, 8'($urandom), rand_hum(), order[i]);
        push_rand(1'b0);
        send_item(klst_pkg::ACT_DUMP, 8'($urandom), rand_hum(), 5'($urandom));
        repeat (4)
            send_item(klst_pkg::ACT_LOOKUP, 8'($urandom), rand_hum(), pick_hour(1'b1));
    endtask

    task automatic random_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 38)      push_rand($urandom_range(99) < 85);
        else if (pick < 58) send_item(klst_pkg::ACT_POP, 8'($urandom), rand_hum(),
                                      5'($urandom));
        else if (pick < 80) send_item(klst_pkg::ACT_LOOKUP, 8'($urandom), rand_hum(),
                                      ($urandom_range(99) < 70) ? pick_hour(1'b1)
                                                                : 5'($urandom));
        else if (pick < 89) send_item(klst_pkg::ACT_DUMP, 8'($urandom), rand_hum(),
                                      5'($urandom));
        else if (pick < 93) send_item(klst_pkg::ACT_CLEAR, 8'($urandom), rand_hum(),
                                      5'($urandom));
        else                send_item(3'($urandom_range(ACT_RSVD5, ACT_RSVD7)),
                                      8'($urandom), rand_hum(), 5'($urandom));
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (answers_due.size() == 0) begin
                flag_mismatch("unexpected item, status", o_m_axis_tuser[2:0], -1);
            end else begin
                want = answers_due.pop_front();
                if (o_m_axis_tuser[2:0] !== want.status)
                    flag_mismatch("status", o_m_axis_tuser[2:0], want.status);
                if (o_m_axis_tuser[3] !== want.has_rec)
                    flag_mismatch("has_record", o_m_axis_tuser[3], want.has_rec);
                if (o_m_axis_tdata[7:0] !== want.rec.temperature)
                    flag_mismatch("temperature", $signed(o_m_axis_tdata[7:0]),
                                  want.rec.temperature);
                if (o_m_axis_tdata[14:8] !== want.rec.humidity)
                    flag_mismatch("humidity", o_m_axis_tdata[14:8], want.rec.humidity);
                if (o_m_axis_tdata[19:15] !== want.rec.hour)
                    flag_mismatch("hour", o_m_axis_tdata[19:15], want.rec.hour);
                if (o_m_axis_tlast !== want.last)
                    flag_mismatch("last", o_m_axis_tlast, want.last);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("** keyed_lifo_stack: FAILED **");
        $finish;
    end

    // result side: random stalls, a calm window, and one long hold-off
    initial begin : sink_drive
        bit held;
        held = 1'b0;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 60) begin
                held = 1'b1;
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = klst_pkg::ACT_PUSH;
        shadow_fill     = 0;
        fails           = 0;
        results_seen    = 0;
        items_sent      = 0;
        quiet_cycles    = 0;
        steady          = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[n]) begin
            send_item(dir_rows[n].act, dir_rows[n].temp, dir_rows[n].hum, dir_rows[n].hour);
            // typed rows replace the predicted answer with the one read off the spec
            if (dir_rows[n].typed) begin
                void'(answers_due.pop_back());
                answers_due.push_back(bare_answer(dir_rows[n].want));
            end
        end

        fill_to_top();
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(99)) inside
                [0:3]:   fill_to_top();
                [4:27]:  repeat ($urandom_range(6, 30)) push_rand($urandom_range(99) < 85);
                [28:37]: repeat ($urandom_range(3, 12))
                             send_item(klst_pkg::ACT_POP, 8'($urandom), rand_hum(),
                                       5'($urandom));
                default: random_op();
            endcase
        end

        i_s_axis_tvalid = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (fails == 0)
            $display("** keyed_lifo_stack: PASSED **");
        else
            $display("** keyed_lifo_stack: FAILED **");
        $finish;
    end

endmodule
